[hdl/tar_pkg.sv]
package tar_pkg;

  localparam int CW   = 24;          // coordinate width
  localparam int SQW  = 2 * CW + 1;  // one squared difference
  localparam int SW   = 2 * CW + 3;  // sum of three squares
  localparam int LW   = CW + 1;      // edge length
  localparam int TW   = LW + 1;      // positive denominator term
  localparam int NW   = 3 * LW;      // numerator a*b*c
  localparam int DW   = 3 * TW;      // denominator product
  localparam int QW   = 32;          // quotient width
  localparam int FRAC = 16;          // fraction bits of the ratio
  localparam int XW   = DW + QW;     // divider working width

  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] az;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] bz;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;
  } tar_in_t;

  typedef struct packed {
    logic [QW-1:0] ratio;
    logic          degenerate;
    logic          saturated;
  } tar_out_t;

  typedef struct packed {
    logic degen;
    logic sat;
  } tar_flag_t;

endpackage

[hdl/tar_sqrt.sv]
module tar_sqrt (
  input  logic                 clk,
  input  logic                 en,
  input  logic [tar_pkg::SW-1:0] rad,
  output logic [tar_pkg::LW-1:0] root
);
  import tar_pkg::*;

  logic [SW-1:0] rem_s  [0:LW];
  logic [LW-1:0] root_s [0:LW];

  assign rem_s[0]  = rad;
  assign root_s[0] = '0;

  // one result bit per stage, residual kept as rad - root^2
  for (genvar g = 0; g < LW; g++) begin : g_stage
    localparam int B = LW - 1 - g;
    logic [SW:0]   trial;
    logic [SW-1:0] rem_r;
    logic [LW-1:0] root_r;

    always_comb begin
      trial = ({(SW + 1 - LW)'(0), root_s[g]} << (B + 1)) + ((SW + 1)'(1) << (2 * B));
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rem_s[g]} >= trial) begin
          rem_r  <= rem_s[g] - trial[SW-1:0];
          root_r <= root_s[g] | (LW'(1) << B);
        end else begin
          rem_r  <= rem_s[g];
          root_r <= root_s[g];
        end
      end
    end

    assign rem_s[g+1]  = rem_r;
    assign root_s[g+1] = root_r;
  end

  assign root = root_s[LW];

endmodule

[hdl/tar_div.sv]
module tar_div (
  input  logic                   clk,
  input  logic                   en,
  input  logic [tar_pkg::XW-1:0] dvd,
  input  logic [tar_pkg::DW-1:0] dvs,
  input  tar_pkg::tar_flag_t     flag_in,
  output logic [tar_pkg::QW-1:0] quo,
  output tar_pkg::tar_flag_t     flag_out
);
  import tar_pkg::*;

  logic [XW-1:0] rem_s  [0:QW];
  logic [DW-1:0] den_s  [0:QW];
  logic [QW-1:0] quo_s  [0:QW];
  tar_flag_t     flag_s [0:QW];

  assign rem_s[0]  = dvd;
  assign den_s[0]  = dvs;
  assign quo_s[0]  = '0;
  assign flag_s[0] = flag_in;

  // restoring division, one quotient bit per stage from the top
  for (genvar g = 0; g < QW; g++) begin : g_stage
    localparam int I = QW - 1 - g;
    logic [XW-1:0] dsh;
    logic [XW-1:0] rem_r;
    logic [DW-1:0] den_r;
    logic [QW-1:0] quo_r;
    tar_flag_t     flag_r;

    assign dsh = XW'(den_s[g]) << I;

    always_ff @(posedge clk) begin
      if (en) begin
        den_r  <= den_s[g];
        flag_r <= flag_s[g];
        if (rem_s[g] >= dsh) begin
          rem_r <= rem_s[g] - dsh;
          quo_r <= quo_s[g] | (QW'(1) << I);
        end else begin
          rem_r <= rem_s[g];
          quo_r <= quo_s[g];
        end
      end
    end

    assign rem_s[g+1]  = rem_r;
    assign den_s[g+1]  = den_r;
    assign quo_s[g+1]  = quo_r;
    assign flag_s[g+1] = flag_r;
  end

  assign quo      = quo_s[QW];
  assign flag_out = flag_s[QW];

endmodule

[hdl/triangle_aspect_ratio.sv]
// channel  direction  ports                         payload
// in       input      in_valid, in_ready, in_data    tar_in_t  (three corners)
// out      output     out_valid, out_ready, out_data tar_out_t (ratio and flags)
//
// one triangle per cycle unless the pipeline holds; the 25-stage square root
// and the 32-stage divider sit among the squaring, product and output stages
// rst_n clears only the valid bits; the data registers carry no reset
// the whole pipeline holds when a result waits at the output and out_ready is low
module triangle_aspect_ratio (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tar_pkg::tar_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tar_pkg::tar_out_t out_data
);
  import tar_pkg::*;

  localparam int LAT = LW + 40;

  logic           en;
  logic [LAT-1:0] vld_r;

  function automatic logic [SQW-1:0] sq_diff(input logic signed [CW-1:0] p,
                                             input logic signed [CW-1:0] q);
    logic signed [CW:0] d;
    logic [CW:0]        m;
    logic [2*CW+1:0]    s;
    d = {p[CW-1], p} - {q[CW-1], q};
    m = d[CW] ? (~d + 1'b1) : d;
    s = m * m;
    return s[SQW-1:0];
  endfunction

  assign en        = !vld_r[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // squared differences and their sums
  logic [SQW-1:0] sq_r  [0:8];
  logic [SW-1:0]  sum_r [0:2];
  logic [LW-1:0]  len   [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0] <= sq_diff(in_data.ax, in_data.bx);
      sq_r[1] <= sq_diff(in_data.ay, in_data.by);
      sq_r[2] <= sq_diff(in_data.az, in_data.bz);
      sq_r[3] <= sq_diff(in_data.bx, in_data.cx);
      sq_r[4] <= sq_diff(in_data.by, in_data.cy);
      sq_r[5] <= sq_diff(in_data.bz, in_data.cz);
      sq_r[6] <= sq_diff(in_data.cx, in_data.ax);
      sq_r[7] <= sq_diff(in_data.cy, in_data.ay);
      sq_r[8] <= sq_diff(in_data.cz, in_data.az);
      for (int e = 0; e < 3; e++) begin
        sum_r[e] <= SW'(sq_r[3*e]) + SW'(sq_r[3*e+1]) + SW'(sq_r[3*e+2]);
      end
    end
  end

  for (genvar e = 0; e < 3; e++) begin : g_len
    tar_sqrt u_sqrt (
      .clk  (clk),
      .en   (en),
      .rad  (sum_r[e]),
      .root (len[e])
    );
  end

  // denominator terms, then products split into partial products
  logic [LW+1:0]   term_r [0:2];
  logic [LW-1:0]   a_t_r, b_t_r, c_t_r;
  logic [2*LW-1:0] ab_r;
  logic [2*TW-1:0] pq_r;
  logic [LW-1:0]   c_m_r;
  logic [TW-1:0]   r_m_r;
  logic            degen_m_r;
  logic [2*LW-1:0] nlo_r, nhi_r;
  logic [2*TW-1:0] dlo_r, dhi_r;
  logic            degen_n_r;
  logic [NW-1:0]   num_r;
  logic [DW-1:0]   den_r;
  logic            degen_o_r;
  logic [XW-1:0]   dvd_r;
  logic [DW-1:0]   dvs_r;
  tar_flag_t       flag_s_r;
  logic            degen_t;

  always_comb begin
    degen_t = 1'b0;
    for (int e = 0; e < 3; e++) begin
      if (term_r[e][LW+1] || term_r[e] == '0) degen_t = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_t_r     <= len[0];
      b_t_r     <= len[1];
      c_t_r     <= len[2];
      term_r[0] <= {2'b00, len[1]} + {2'b00, len[2]} - {2'b00, len[0]};
      term_r[1] <= {2'b00, len[2]} + {2'b00, len[0]} - {2'b00, len[1]};
      term_r[2] <= {2'b00, len[0]} + {2'b00, len[1]} - {2'b00, len[2]};

      ab_r      <= a_t_r * b_t_r;
      pq_r      <= term_r[0][TW-1:0] * term_r[1][TW-1:0];
      c_m_r     <= c_t_r;
      r_m_r     <= term_r[2][TW-1:0];
      degen_m_r <= degen_t;

      nlo_r     <= ab_r[LW-1:0] * c_m_r;
      nhi_r     <= ab_r[2*LW-1:LW] * c_m_r;
      dlo_r     <= pq_r[TW-1:0] * r_m_r;
      dhi_r     <= pq_r[2*TW-1:TW] * r_m_r;
      degen_n_r <= degen_m_r;

      num_r     <= {{LW{1'b0}}, nlo_r} + {nhi_r, {LW{1'b0}}};
      den_r     <= {{TW{1'b0}}, dlo_r} + {dhi_r, {TW{1'b0}}};
      degen_o_r <= degen_n_r;

      // quotient of 2^32 or more saturates
      dvd_r          <= {{(XW - NW - FRAC){1'b0}}, num_r, {FRAC{1'b0}}};
      dvs_r          <= den_r;
      flag_s_r.degen <= degen_o_r;
      flag_s_r.sat   <= {{(XW - NW - FRAC){1'b0}}, num_r, {FRAC{1'b0}}}
                        >= {den_r, {QW{1'b0}}};
    end
  end

  logic [QW-1:0] quo;
  tar_flag_t     flag_q;
  tar_out_t      out_r;

  tar_div u_div (
    .clk      (clk),
    .en       (en),
    .dvd      (dvd_r),
    .dvs      (dvs_r),
    .flag_in  (flag_s_r),
    .quo      (quo),
    .flag_out (flag_q)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.ratio      <= (flag_q.degen || flag_q.sat) ? '1 : quo;
      out_r.degenerate <= flag_q.degen;
      out_r.saturated  <= flag_q.sat && !flag_q.degen;
    end
  end

  assign out_data = out_r;

`ifndef SYNTH
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.degenerate && out_data.saturated))
    else $error("degenerate and saturated both set");

  a_degen_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.degenerate) |-> (out_data.ratio == '1))
    else $error("degenerate result not at maximum");

  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.saturated) |-> (out_data.ratio == '1))
    else $error("saturated result not at maximum");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(vld_r))
    else $error("pipeline moved during a stalled transfer");
`endif

endmodule

[tb/tb_triangle_aspect_ratio.sv]
`timescale 1ns / 100ps

module tb_triangle_aspect_ratio;
  import tar_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  tar_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  tar_out_t out_data;

  tar_in_t  pending_tris[$];
  tar_out_t expected_ratios[$];
  int       err_count = 0;
  int       send_idle_pct = 13;
  int       recv_idle_pct = 80;

  always #2 clk = ~clk;

  triangle_aspect_ratio u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // floor square root of a sum of three squares
  function automatic logic [63:0] isqrt(logic [127:0] s);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int bt = 33; bt >= 0; bt--) begin
      t = r | (64'd1 << bt);
      if ({64'd0, t} * {64'd0, t} <= s) r = t;
    end
    return r;
  endfunction

  function automatic logic [63:0] edge_length(logic signed [CW-1:0] x0, y0, z0,
                                              logic signed [CW-1:0] x1, y1, z1);
    logic signed [63:0] dx, dy, dz;
    logic [127:0] s;
    dx = 64'(x0) - 64'(x1);
    dy = 64'(y0) - 64'(y1);
    dz = 64'(z0) - 64'(z1);
    s = 128'(dx * dx) + 128'(dy * dy) + 128'(dz * dz);
    return isqrt(s);
  endfunction

  function automatic tar_out_t quality_ratio(tar_in_t t);
    logic signed [63:0] a, b, c, p, q, r;
    logic [255:0] num, den, quo;
    tar_out_t o;
    a = edge_length(t.ax, t.ay, t.az, t.bx, t.by, t.bz);
    b = edge_length(t.bx, t.by, t.bz, t.cx, t.cy, t.cz);
    c = edge_length(t.cx, t.cy, t.cz, t.ax, t.ay, t.az);
    p = b + c - a;
    q = c + a - b;
    r = a + b - c;
    o = '0;
    if (p <= 0 || q <= 0 || r <= 0) begin
      o.ratio = '1;
      o.degenerate = 1'b1;
      return o;
    end
    num = 256'(a) * 256'(b) * 256'(c);
    den = 256'(p) * 256'(q) * 256'(r);
    quo = (num << FRAC) / den;
    if (quo >= (256'd1 << QW)) begin
      o.ratio = '1;
      o.saturated = 1'b1;
    end else begin
      o.ratio = quo[QW-1:0];
    end
    return o;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord(int span);
    int v;
    if (span <= 0) return CW'($urandom);
    v = $urandom_range(2 * span, 0) - span;
    return CW'(v);
  endfunction

  // triangles around a random centre with tuned spread, some collinear, some fully random
  function automatic tar_in_t rand_triangle();
    tar_in_t t;
    int span;
    int mode;
    logic signed [CW-1:0] ox, oy, oz;
    mode = $urandom_range(9, 0);
    span = (mode < 2) ? 0 : (mode < 5) ? $urandom_range(4095, 1) : $urandom_range(4194303, 1);
    ox = CW'($urandom) >>> 2;
    oy = CW'($urandom) >>> 2;
    oz = CW'($urandom) >>> 2;
    t.ax = ox + rand_coord(span);
    t.ay = oy + rand_coord(span);
    t.az = oz + rand_coord(span);
    t.bx = ox + rand_coord(span);
    t.by = oy + rand_coord(span);
    t.bz = oz + rand_coord(span);
    if (mode == 9) begin
      // collinear: c repeats a step of a to b
      t.cx = CW'(2 * t.bx - t.ax);
      t.cy = CW'(2 * t.by - t.ay);
      t.cz = CW'(2 * t.bz - t.az);
    end else begin
      t.cx = ox + rand_coord(span);
      t.cy = oy + rand_coord(span);
      t.cz = oz + rand_coord(span);
    end
    if (span == 0)
      t = tar_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     24'($urandom)});
    return t;
  endfunction

  function automatic tar_in_t make_tri(int ax, ay, az, bx, by, bz, cx, cy, cz);
    tar_in_t t;
    t.ax = CW'(ax); t.ay = CW'(ay); t.az = CW'(az);
    t.bx = CW'(bx); t.by = CW'(by); t.bz = CW'(bz);
    t.cx = CW'(cx); t.cy = CW'(cy); t.cz = CW'(cz);
    return t;
  endfunction

  function automatic void queue_tri(tar_in_t t);
    pending_tris.insert(pending_tris.size(), t);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) expected_ratios.insert(expected_ratios.size(), quality_ratio(in_data));
      if (pending_tris.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_data  <= pending_tris.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    tar_out_t exp_r;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_ratios.size() == 0) begin
          err_count++;
          if (err_count <= 10) $display("unexpected transfer: %h", out_data);
        end else begin
          exp_r = expected_ratios.pop_front();
          if (out_data.ratio !== exp_r.ratio || out_data.degenerate !== exp_r.degenerate ||
              out_data.saturated !== exp_r.saturated) begin
            err_count++;
            if (err_count <= 10)
              $display("mismatch: ratio %h/%h degenerate %b/%b saturated %b/%b (exp/act)",
                       exp_r.ratio, out_data.ratio, exp_r.degenerate, out_data.degenerate,
                       exp_r.saturated, out_data.saturated);
          end
        end
      end
      out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  initial begin
    int m;
    m = 8388607;
    queue_tri(make_tri(0, 0, 0, 1000, 0, 0, 500, 866, 0));
    queue_tri(make_tri(0, 0, 0, 4096, 0, 0, 2048, 3547, 0));
    queue_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_tri(make_tri(5, 5, 5, 5, 5, 5, 9, 1, 3));
    queue_tri(make_tri(0, 0, 0, 1, 1, 1, 2, 2, 2));
    queue_tri(make_tri(0, 0, 0, 3000000, 0, 0, 1500000, 1, 0));
    queue_tri(make_tri(0, 0, 0, 10000, 0, 0, 5000, 1, 0));
    queue_tri(make_tri(-m-1, -m-1, -m-1, m, m, m, -m-1, m, 0));
    queue_tri(make_tri(m, m, m, -m-1, -m-1, -m-1, m, -m-1, m));
    queue_tri(make_tri(-m-1, 0, 0, m, 0, 0, 0, m, 0));
    queue_tri(make_tri(m, -m-1, m, -m-1, m, -m-1, 0, 0, 0));
    queue_tri(make_tri(-1, -1, -1, 1, 1, 1, -1, 1, -1));
    queue_tri(make_tri(0, 0, 0, 3, 0, 0, 0, 4, 0));
    queue_tri(make_tri(m, m, m, m, m, m, m, m, m));
    queue_tri(tar_in_t'({9{24'h555555}}));
    queue_tri(tar_in_t'({9{24'hAAAAAA}}));
    for (int i = 0; i < 1400; i++) queue_tri(rand_triangle());
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_tris.size() < 930);
    send_idle_pct = 80;
    recv_idle_pct = 13;
    wait (pending_tris.size() < 460);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait (pending_tris.size() == 0);
    @(posedge clk);
    while (in_valid) @(posedge clk);
    @(posedge clk);
    while (expected_ratios.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[files.f]
hdl/tar_pkg.sv
hdl/tar_sqrt.sv
hdl/tar_div.sv
hdl/triangle_aspect_ratio.sv
tb/tb_triangle_aspect_ratio.sv
